// File: sv/owsx_pkg.sv
// ----------------------------------------------------------------------------
// owsx_pkg
// Shared types, constants and helpers of the wall segment extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package owsx_pkg;

  localparam int DEFAULT_MAX_COLUMNS = 1024;
  localparam int DEFAULT_MAX_ROWS    = 1024;

  // Register and coordinate widths are fixed by the external format.
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int COORD_W    = 11;
  localparam int CELL_W     = 8;
  localparam int KIND_W     = 2;
  localparam int GRID_RESET = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_HORIZONTAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VERTICAL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BOX        = 2'd2;

  localparam logic signed [CELL_W-1:0] OCCUPIED_CODE = 8'sd100;
  localparam logic signed [CELL_W-1:0] UNKNOWN_CODE  = -8'sd1;

  // Result queue between the front and the back; a power of two.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
  } res_t;

  // All results caused by one cell; r1 is used only when two is set.
  typedef struct packed {
    logic two;
    res_t r1;
    res_t r0;
  } pair_t;

  // A size register of zero acts as one, and values above the limit saturate.
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int unsigned maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > maxv) begin
      r = CFG_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/owsx_ram.sv
// ----------------------------------------------------------------------------
// owsx_ram
// Simple dual-port RAM, one write and one registered read-first port.
// ----------------------------------------------------------------------------
`default_nettype none

module owsx_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/owsx_front.sv
// ----------------------------------------------------------------------------
// owsx_front
// Configuration, raster position, line buffers and run tracking; emits the
// results of each cell as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module owsx_front
  import owsx_pkg::*;
#(
  parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEFAULT_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           in_valid,
  input  logic signed [CELL_W-1:0]       cell_value,
  output logic                           in_ready,
  input  logic [LVL_W-1:0]               fifo_level,
  output logic                           push,
  output pair_t                          push_data
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);

  logic [CFG_W-1:0] grid_columns;
  logic [CFG_W-1:0] grid_rows;
  logic             edge_mode;

  logic [CW-1:0] col_idx;
  logic [RW-1:0] row_idx;

  logic accept;
  logic cell_bit;
  logic last_col_now;
  logic last_row_now;

  // Stage register: the cell whose line-buffer reads are landing this cycle.
  logic          s_valid;
  logic          s_bit;
  logic [CW-1:0] s_c;
  logic [RW-1:0] s_r;
  logic          s_first_row;
  logic          s_first_col;
  logic          s_last_col;
  logic          s_last_row;

  logic          row_run_open;
  logic [CW-1:0] row_run_start;
  logic          left_bit;

  logic          above_bit;
  logic [RW:0]   col_rd;
  logic [RW:0]   col_wr;
  logic          col_we;

  logic          col_open_old;
  logic [RW-1:0] col_start_old;
  logic          ro_next;
  logic [CW-1:0] rs_next;
  logic          co_next;
  logic [RW-1:0] cs_next;
  logic          h_emit;
  logic          v_emit;
  logic          box_emit;
  logic [COORD_W-1:0] h_end;
  logic [COORD_W-1:0] v_end;
  res_t          h_res;
  res_t          v_res;
  res_t          box_res;

  // The queue must hold every entry already in flight.
  assign in_ready = ({1'b0, fifo_level} + (LVL_W + 1)'(s_valid)) < (LVL_W + 1)'(FIFO_DEPTH);
  assign accept   = in_valid && in_ready;
  assign cell_bit = (cell_value == OCCUPIED_CODE) || (cell_value == UNKNOWN_CODE);
  assign last_col_now = (32'(col_idx) + 32'd1) == 32'(grid_columns);
  assign last_row_now = (32'(row_idx) + 32'd1) == 32'(grid_rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= CFG_W'(GRID_RESET > MAX_COLUMNS ? MAX_COLUMNS : GRID_RESET);
      grid_rows    <= CFG_W'(GRID_RESET > MAX_ROWS ? MAX_ROWS : GRID_RESET);
      edge_mode    <= 1'b1;
      col_idx      <= '0;
      row_idx      <= '0;
      s_valid      <= 1'b0;
      row_run_open <= 1'b0;
    end else begin
      s_valid <= accept;
      if (cfg_valid && (cfg_index == CFG_COLUMNS || cfg_index == CFG_ROWS ||
                        cfg_index == CFG_EDGE_MODE)) begin
        case (cfg_index)
          CFG_COLUMNS:   grid_columns <= clamp_size(cfg_data, MAX_COLUMNS);
          CFG_ROWS:      grid_rows    <= clamp_size(cfg_data, MAX_ROWS);
          CFG_EDGE_MODE: edge_mode    <= cfg_data[0];
          default:       edge_mode    <= edge_mode;
        endcase
        // Any known register write restarts the grid and drops open runs.
        col_idx      <= '0;
        row_idx      <= '0;
        row_run_open <= 1'b0;
      end else begin
        if (accept) begin
          if (last_col_now) begin
            col_idx <= '0;
            row_idx <= last_row_now ? '0 : row_idx + RW'(1);
          end else begin
            col_idx <= col_idx + CW'(1);
          end
        end
        if (s_valid && edge_mode) begin
          row_run_open <= ro_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_bit       <= cell_bit;
      s_c         <= col_idx;
      s_r         <= row_idx;
      s_first_row <= (row_idx == '0);
      s_first_col <= (col_idx == '0);
      s_last_col  <= last_col_now;
      s_last_row  <= last_row_now;
    end
    if (s_valid) begin
      left_bit <= s_bit;
      if (edge_mode) begin
        row_run_start <= rs_next;
      end
    end
  end

  // Cell bits of the previous row. Written at accept so that a one-column
  // grid sees the cell directly above in the next cycle.
  owsx_ram #(
    .WIDTH (1),
    .DEPTH (MAX_COLUMNS)
  ) u_row_above (
    .clk   (clk),
    .we    (accept),
    .waddr (col_idx),
    .wdata (cell_bit),
    .re    (accept),
    .raddr (col_idx),
    .rdata (above_bit)
  );

  // Per-column vertical run state: open flag and start row. Entries are
  // never cleared; on the first row of a grid the open flag is taken as
  // clear, which is also what a completed earlier grid has left behind.
  owsx_ram #(
    .WIDTH (RW + 1),
    .DEPTH (MAX_COLUMNS)
  ) u_col_run (
    .clk   (clk),
    .we    (col_we),
    .waddr (s_c),
    .wdata (col_wr),
    .re    (accept),
    .raddr (col_idx),
    .rdata (col_rd)
  );

  assign col_open_old  = s_first_row ? 1'b0 : col_rd[RW];
  assign col_start_old = col_rd[RW-1:0];
  assign col_wr        = {co_next, cs_next};
  assign col_we        = s_valid && edge_mode && !s_first_col;

  always_comb begin
    ro_next  = row_run_open;
    rs_next  = row_run_start;
    co_next  = col_open_old;
    cs_next  = col_start_old;
    h_emit   = 1'b0;
    v_emit   = 1'b0;
    h_end    = COORD_W'(s_c);
    v_end    = COORD_W'(s_r);
    if (edge_mode) begin
      if (!s_first_row) begin
        if ((s_bit != above_bit) && !ro_next) begin
          ro_next = 1'b1;
          rs_next = s_c;
        end else if ((s_bit == above_bit) && ro_next) begin
          h_emit  = 1'b1;
          h_end   = COORD_W'(s_c);
          ro_next = 1'b0;
        end
        if (s_last_col && ro_next) begin
          h_emit  = 1'b1;
          h_end   = COORD_W'(grid_columns);
          ro_next = 1'b0;
        end
      end
      if (!s_first_col) begin
        if ((s_bit != left_bit) && !co_next) begin
          co_next = 1'b1;
          cs_next = s_r;
        end else if ((s_bit == left_bit) && co_next) begin
          v_emit  = 1'b1;
          v_end   = COORD_W'(s_r);
          co_next = 1'b0;
        end
        if (s_last_row && co_next) begin
          v_emit  = 1'b1;
          v_end   = COORD_W'(grid_rows);
          co_next = 1'b0;
        end
      end
    end
    box_emit = !edge_mode && s_bit;
  end

  always_comb begin
    h_res.kind = KIND_HORIZONTAL;
    h_res.sx   = COORD_W'(rs_next);
    h_res.sy   = COORD_W'(s_r - RW'(1));
    h_res.ex   = h_end;
    h_res.ey   = COORD_W'(s_r - RW'(1));

    v_res.kind = KIND_VERTICAL;
    v_res.sx   = COORD_W'(s_c - CW'(1));
    v_res.sy   = COORD_W'(cs_next);
    v_res.ex   = COORD_W'(s_c - CW'(1));
    v_res.ey   = v_end;

    box_res.kind = KIND_BOX;
    box_res.sx   = COORD_W'(s_c);
    box_res.sy   = COORD_W'(s_r);
    box_res.ex   = COORD_W'(s_c) + COORD_W'(1);
    box_res.ey   = COORD_W'(s_r) + COORD_W'(1);

    // The horizontal result goes first when a cell causes both.
    push_data.two = h_emit && v_emit;
    push_data.r0  = h_emit ? h_res : (v_emit ? v_res : box_res);
    push_data.r1  = v_res;
  end

  assign push = s_valid && (h_emit || v_emit || box_emit);

  a_col_in_grid: assert property (@(posedge clk) disable iff (rst)
    32'(col_idx) < 32'(grid_columns))
    else $error("column position outside the grid");

  a_no_edge_on_top_row: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_first_row |-> !h_emit)
    else $error("horizontal edge reported on the first row");

endmodule

`default_nettype wire

// File: sv/owsx_fifo.sv
// ----------------------------------------------------------------------------
// owsx_fifo
// Short queue of per-cell result entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module owsx_fifo
  import owsx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pair_t            push_data,
  input  logic             pop,
  output pair_t            head,
  output logic             head_valid,
  output logic [LVL_W-1:0] level
);

  pair_t            entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + LVL_W'(1);
      end else if (pop && !push) begin
        count <= count - LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign level      = count;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> 32'(count) < FIFO_DEPTH)
    else $error("result queue overflow");

endmodule

`default_nettype wire

// File: sv/owsx_back.sv
// ----------------------------------------------------------------------------
// owsx_back
// Output register; splits each queue entry into one or two result items.
// ----------------------------------------------------------------------------
`default_nettype none

module owsx_back
  import owsx_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  pair_t head,
  input  logic  head_valid,
  output logic  pop,
  input  logic  out_ready,
  output logic  out_valid,
  output res_t  out_res,
  output logic  out_last
);

  logic take;
  logic sel;

  assign take = !out_valid || out_ready;
  assign pop  = take && head_valid && (sel || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (take) begin
      out_valid <= head_valid;
      if (head_valid) begin
        sel <= !sel && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && head_valid) begin
      out_res  <= sel ? head.r1 : head.r0;
      out_last <= sel || !head.two;
    end
  end

  a_second_needs_pair: assert property (@(posedge clk) disable iff (rst)
    sel |-> head_valid && head.two)
    else $error("second result selected without a two-result entry");

endmodule

`default_nettype wire

// File: sv/occupancy_grid_wall_segment_extract.sv
// ----------------------------------------------------------------------------
// occupancy_grid_wall_segment_extract
// Turns a raster stream of occupancy grid cells into wall segments or boxes.
// ----------------------------------------------------------------------------
// Cells enter one per item in raster order, row 0 first and columns left to
// right; a cell is a wall when its code is 100 or -1. In edge mode each cell
// is compared with the cell above and the cell to its left, and every maximal
// run of differing pairs leaves as one horizontal or vertical segment in cell
// units (exclusive end), closed at the first equal pair or at the grid edge.
// In box mode every wall cell gives one box. A cell causes zero, one or two
// result items; the horizontal one comes first and tlast marks the last item
// of each cell. The block takes one cell per clock cycle while the queue
// has room and delivers one result per cycle while the output is ready; a
// cell's results pass through the stage register and the result queue into
// the output register. The output port sets the sustained rate: a four-entry
// result queue between the cell front end and the output register absorbs
// short bursts, and the input stalls once the queue and the cell in flight
// fill it. Two line buffers of MAX_COLUMNS entries hold the row above and the
// open vertical runs; no clearing pass is needed after reset. Any write to a
// known register restarts the grid at row 0, column 0 and drops open runs
// silently; the user, not the block, must see that writes go in while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_grid_wall_segment_extract
  import owsx_pkg::*;
#(
  parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEFAULT_MAX_ROWS
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // Cell stream.
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic signed [CELL_W-1:0] s_tdata,  // [7:0] cell_value
  // Result stream.
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [47:0]              m_tdata,  // [1:0] seg_kind, [12:2] start_x,
                                             // [23:13] start_y, [34:24] end_x,
                                             // [45:35] end_y, [47:46] zero
  output logic                     m_tlast   // last_of_item
);

  pair_t            push_data;
  logic             push;
  pair_t            head;
  logic             head_valid;
  logic             pop;
  logic [LVL_W-1:0] fifo_level;
  res_t             out_res;

  // Registers are always writable; the user, not the block, keeps it idle when they change.
  assign cfg_ready = 1'b1;

  owsx_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .cell_value (s_tdata),
    .in_ready   (s_tready),
    .fifo_level (fifo_level),
    .push       (push),
    .push_data  (push_data)
  );

  owsx_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (fifo_level)
  );

  owsx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_res    (out_res),
    .out_last   (m_tlast)
  );

  // Fields packed from the lowest bit up, padded to whole bytes.
  assign m_tdata = {2'b00, out_res.ey, out_res.ex, out_res.sy, out_res.sx, out_res.kind};

endmodule

`default_nettype wire
